/* design/sbta_pkg.sv */
// Shared types, constants and bf16 arithmetic functions for the bf16 SiLU pipeline.
`timescale 1ns / 1ps
`default_nettype none

package sbta_pkg;

    // Number of series terms; the pipeline depth follows from it.
    localparam int TAYLOR_TERMS = 16;
    localparam int TAY_STAGES   = 3 * (TAYLOR_TERMS - 1);
    localparam int PH_POW       = 0;
    localparam int PH_TERM      = 1;

    // Reciprocal: one quotient bit per stage.
    localparam int DIV_BITS  = 12;
    localparam int REM_W     = DIV_BITS + 7;
    localparam int PIPE_DEPTH = TAY_STAGES + DIV_BITS + 5;

    localparam logic [15:0] BF_ONE   = 16'h3F80;
    localparam logic [15:0] BF_QNAN  = 16'h7FC0;
    localparam logic [15:0] BF_SLOPE = 16'h3B86;  // 0.0041
    localparam logic [15:0] BF_OFF   = 16'h3F79;  // 0.9727
    localparam logic [14:0] MAG_FOUR  = 15'h4080;
    localparam logic [14:0] MAG_SEVEN = 15'h40E0;

    typedef enum logic [1:0] {
        DEN_FIN,
        DEN_ZERO,
        DEN_INF,
        DEN_NAN
    } den_cls_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] lin;
        logic        gt4;
        logic        gt7;
        logic        ltm7;
    } side_t;

    typedef struct packed {
        side_t       sd;
        logic [15:0] pow;
        logic [15:0] term;
        logic [15:0] sum;
    } tay_t;

    typedef struct packed {
        side_t              sd;
        den_cls_t           cls;
        logic               dsign;
        logic signed [11:0] ed;
    } uinfo_t;

    function automatic logic is_nan(input logic [15:0] a);
        return (a[14:7] == 8'hFF) && (a[6:0] != 7'd0);
    endfunction

    function automatic logic is_inf(input logic [15:0] a);
        return (a[14:7] == 8'hFF) && (a[6:0] == 7'd0);
    endfunction

    // 1/k! in bf16; the sign is set for odd k so the series alternates.
    function automatic logic [15:0] term_coef(input int k);
        logic [15:0] c;
        case (k)
            2:       c = 16'h3F00;
            3:       c = 16'hBE2B;
            4:       c = 16'h3D2B;
            5:       c = 16'hBC09;
            6:       c = 16'h3AB6;
            7:       c = 16'hB950;
            8:       c = 16'h37D0;
            9:       c = 16'hB639;
            10:      c = 16'h3494;
            11:      c = 16'hB2D7;
            12:      c = 16'h310F;
            13:      c = 16'hAF31;
            14:      c = 16'h2D4A;
            15:      c = 16'hAB57;
            16:      c = 16'h2957;
            default: c = 16'h0000;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] lz8(input logic [7:0] v);
        logic [2:0] n;
        logic       found;
        n = 3'd0;
        found = 1'b0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!found && v[i])
            begin
                n = 3'(7 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // value = sig * 2^(e-31), plus sticky below; round nearest-even to bf16
    // with subnormals, overflow to infinity.
    function automatic logic [15:0] round_pack(input logic sgn, input logic signed [11:0] e,
                                               input logic [31:0] sig, input logic sticky);
        logic [5:0]         lz;
        logic               found;
        logic [31:0]        n;
        logic signed [11:0] be;
        logic [11:0]        shr;
        logic [63:0]        ext;
        logic               st;
        logic               up;
        logic [8:0]         q9;
        logic [16:0]        fld;
        logic [15:0]        r;
        lz = 6'd0;
        found = 1'b0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!found && sig[i])
            begin
                lz = 6'(31 - i);
                found = 1'b1;
            end
        end
        n = sig << lz;
        be = e - $signed({6'b0, lz}) + 12'sd127;
        if (be >= 12'sd1)
            shr = 12'd0;
        else
        begin
            shr = 12'sd1 - be;
            if (shr > 12'd40)
                shr = 12'd40;
        end
        ext = {n, 32'b0};
        st = sticky | (|(ext & ((64'd1 << shr) - 64'd1)));
        ext = ext >> shr;
        up = ext[55] & ((|ext[54:0]) | st | ext[56]);
        q9 = {1'b0, ext[63:56]} + {8'b0, up};
        fld = (be >= 12'sd1) ? {be[9:0] - 10'd1, 7'b0} : 17'd0;
        fld = fld + {8'b0, q9};
        if (sig == 32'd0)
            r = {sgn, 15'd0};
        else if (fld >= 17'h07F80)
            r = {sgn, 15'h7F80};
        else
            r = {sgn, fld[14:0]};
        return r;
    endfunction

    function automatic logic [15:0] bf_mul(input logic [15:0] a, input logic [15:0] b);
        logic        s;
        logic [7:0]  fa;
        logic [7:0]  fb;
        logic [7:0]  xa;
        logic [7:0]  xb;
        logic [15:0] p;
        logic [15:0] r;
        s = a[15] ^ b[15];
        fa = {a[14:7] != 8'd0, a[6:0]};
        fb = {b[14:7] != 8'd0, b[6:0]};
        xa = (a[14:7] == 8'd0) ? 8'd1 : a[14:7];
        xb = (b[14:7] == 8'd0) ? 8'd1 : b[14:7];
        p = fa * fb;
        if (is_nan(a) || is_nan(b) || (is_inf(a) && b[14:0] == 15'd0)
            || (is_inf(b) && a[14:0] == 15'd0))
            r = BF_QNAN;
        else if (is_inf(a) || is_inf(b))
            r = {s, 15'h7F80};
        else if (a[14:0] == 15'd0 || b[14:0] == 15'd0)
            r = {s, 15'd0};
        else
            r = round_pack(s, $signed({4'b0, xa}) + $signed({4'b0, xb}) - 12'sd253,
                           {p, 16'b0}, 1'b0);
        return r;
    endfunction

    function automatic logic [15:0] bf_add(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] big;
        logic [15:0] sml;
        logic [7:0]  fg;
        logic [7:0]  fs;
        logic [7:0]  xg;
        logic [7:0]  xs;
        logic [7:0]  d;
        logic [17:0] bfull;
        logic [17:0] bs;
        logic        st;
        logic [18:0] s;
        logic [15:0] r;
        if (a[14:0] >= b[14:0])
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
        fg = {big[14:7] != 8'd0, big[6:0]};
        fs = {sml[14:7] != 8'd0, sml[6:0]};
        xg = (big[14:7] == 8'd0) ? 8'd1 : big[14:7];
        xs = (sml[14:7] == 8'd0) ? 8'd1 : sml[14:7];
        d = xg - xs;
        bfull = {fs, 10'b0};
        if (d >= 8'd18)
        begin
            bs = 18'd0;
            st = |fs;
        end
        else
        begin
            bs = bfull >> d;
            st = |(bfull & ((18'd1 << d) - 18'd1));
        end
        // sticky jammed into the lsb; ten guard bits keep rounding exact
        if (big[15] == sml[15])
            s = {1'b0, fg, 10'b0} + {1'b0, bs | {17'b0, st}};
        else
            s = {1'b0, fg, 10'b0} - {1'b0, bs | {17'b0, st}};
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && a[15] != b[15]))
            r = BF_QNAN;
        else if (is_inf(a))
            r = a;
        else if (is_inf(b))
            r = b;
        else if (big[14:0] == 15'd0)
            r = {a[15] & b[15], 15'd0};
        else if (s == 19'd0)
            r = 16'h0000;
        else
            r = round_pack(big[15], $signed({4'b0, xg}) - 12'sd126, {s, 13'b0}, 1'b0);
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/sbta_recip.sv */
// Pipelined restoring reciprocal of a normalized 8-bit mantissa, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module sbta_recip
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [7:0]                    m,
    output logic                               out_valid,
    output logic [sbta_pkg::DIV_BITS-1:0]      q,
    output logic                               rem_nz
);

    localparam int N  = sbta_pkg::DIV_BITS;
    localparam int RW = sbta_pkg::REM_W;

    logic [RW-1:0] rem_reg [1:N];
    logic [N-1:0]  q_reg   [1:N];
    logic [7:0]    m_reg   [1:N];
    logic          v_reg   [1:N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic [RW-1:0] rem_in;
        logic [RW-1:0] rem_next;
        logic [RW-1:0] dv;
        logic [N-1:0]  q_in;
        logic [N-1:0]  q_next;
        logic [7:0]    m_in;
        logic          v_in;

        if (i == 0)
        begin : g_first
            // dividend 2^(N+6): quotient lands in [2^(N-2), 2^(N-1)]
            assign rem_in = RW'(1) << (N + 6);
            assign q_in   = '0;
            assign m_in   = m;
            assign v_in   = in_valid;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i];
            assign q_in   = q_reg[i];
            assign m_in   = m_reg[i];
            assign v_in   = v_reg[i];
        end

        assign dv = RW'(m_in) << (N - 1 - i);

        always_comb
        begin
            rem_next = rem_in;
            q_next   = q_in;
            if (rem_in >= dv)
            begin
                rem_next = rem_in - dv;
                q_next   = q_in | (N'(1) << (N - 1 - i));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1] <= rem_next;
            q_reg[i+1]   <= q_next;
            m_reg[i+1]   <= m_in;
        end
    end

    assign out_valid = v_reg[N];
    assign q         = q_reg[N];
    assign rem_nz    = (rem_reg[N] != '0);

    a_in_norm: assert property (@(posedge clk) disable iff (!rst_n) in_valid |-> m[7])
        else $error("reciprocal input not normalized");
    a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (q[N-1] || q[N-2]))
        else $error("reciprocal quotient out of range");
    a_q_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && q[N-1]) |-> (q[N-2:0] == '0 && !rem_nz))
        else $error("reciprocal top quotient must be exact power of two");

endmodule

`default_nettype wire

/* design/silu_bf16_taylor_approx_top.sv */
// Top level: bf16 SiLU, y = x * sigmoid(x), with a series-expanded exp(-x).
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Drive x_bits and pulse start; a beat is taken at every rising edge with
//   start high and busy low. busy is always low: a new beat can enter on
//   every cycle, so throughput is one value per clock.
//   Each result comes out on y_bits with done high for exactly one cycle;
//   results leave in input order. The receiver cannot stall the block;
//   nothing is held back.
//   The path runs through the series pipe (three stages per term: power,
//   term, accumulate; 45 stages for 16 terms), two adds, a normalize stage,
//   the 12-stage pipelined reciprocal, a rounding/select stage and the
//   final multiply.
//   Reset (rst_n low, asynchronous) clears every valid bit; beats in
//   flight are dropped and done stays low until new beats arrive.

module silu_bf16_taylor_approx_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] x_bits,
    output logic             busy,
    output logic             done,
    output logic [15:0]      y_bits
);

    localparam int NT = sbta_pkg::TAY_STAGES;
    localparam int ND = sbta_pkg::DIV_BITS;

    sbta_pkg::tay_t   tay_reg [0:NT];
    logic             tv_reg  [0:NT];
    sbta_pkg::tay_t   tay_entry;
    logic             x_nan;

    sbta_pkg::side_t  e_sd_reg;
    logic [15:0]      e_val_reg;
    logic             ev_reg;
    sbta_pkg::side_t  d_sd_reg;
    logic [15:0]      d_den_reg;
    logic             dv_reg;
    sbta_pkg::uinfo_t u_next;
    sbta_pkg::uinfo_t u_reg;
    logic [7:0]       u_m_next;
    logic [7:0]       u_m_reg;
    logic             uv_reg;
    sbta_pkg::uinfo_t ln_reg  [0:ND-1];
    logic             rv;
    logic [ND-1:0]    rq;
    logic             rnz;
    logic [15:0]      sig_next;
    sbta_pkg::side_t  r_sd_reg;
    logic [15:0]      r_sig_reg;
    logic             r_v_reg;
    logic [15:0]      y_reg;
    logic             done_reg;

    assign busy = 1'b0;

    // entry: range flags and lin path inputs ride with the beat
    always_comb
    begin
        x_nan = sbta_pkg::is_nan(x_bits);
        tay_entry.sd.x    = x_bits;
        tay_entry.sd.lin  = 16'h0000;
        tay_entry.sd.gt4  = !x_bits[15] && !x_nan && (x_bits[14:0] > sbta_pkg::MAG_FOUR);
        tay_entry.sd.gt7  = !x_bits[15] && !x_nan && (x_bits[14:0] > sbta_pkg::MAG_SEVEN);
        tay_entry.sd.ltm7 = x_bits[15] && !x_nan && (x_bits[14:0] > sbta_pkg::MAG_SEVEN);
        tay_entry.pow     = x_bits;
        tay_entry.term    = 16'h0000;
        tay_entry.sum     = x_bits ^ 16'h8000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tv_reg[0] <= 1'b0;
        else
            tv_reg[0] <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        tay_reg[0] <= tay_entry;
    end

    for (genvar j = 0; j < NT; j++)
    begin : g_tay
        localparam int K  = 2 + j / 3;
        localparam int PH = j % 3;
        sbta_pkg::tay_t t_next;

        always_comb
        begin
            t_next = tay_reg[j];
            case (PH)
                sbta_pkg::PH_POW:
                    t_next.pow = sbta_pkg::bf_mul(tay_reg[j].pow, tay_reg[j].sd.x);
                sbta_pkg::PH_TERM:
                    t_next.term = sbta_pkg::bf_mul(tay_reg[j].pow, sbta_pkg::term_coef(K));
                default:
                    t_next.sum = sbta_pkg::bf_add(tay_reg[j].sum, tay_reg[j].term);
            endcase
            // linear segment for x > 4 computed in the first two stages
            if (j == 0)
                t_next.sd.lin = sbta_pkg::bf_mul(tay_reg[j].sd.x, sbta_pkg::BF_SLOPE);
            if (j == 1)
                t_next.sd.lin = sbta_pkg::bf_add(tay_reg[j].sd.lin, sbta_pkg::BF_OFF);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                tv_reg[j+1] <= 1'b0;
            else
                tv_reg[j+1] <= tv_reg[j];
        end

        always_ff @(posedge clk)
        begin
            tay_reg[j+1] <= t_next;
        end
    end

    // denominator: 1 + exp(-x), exp(-x) = 1 + series sum
    always_comb
    begin
        u_next.sd    = d_sd_reg;
        u_next.dsign = d_den_reg[15];
        u_next.cls   = sbta_pkg::DEN_FIN;
        u_next.ed    = 12'sd0;
        u_m_next     = 8'h80;
        if (sbta_pkg::is_nan(d_den_reg))
            u_next.cls = sbta_pkg::DEN_NAN;
        else if (sbta_pkg::is_inf(d_den_reg))
            u_next.cls = sbta_pkg::DEN_INF;
        else if (d_den_reg[14:0] == 15'd0)
            u_next.cls = sbta_pkg::DEN_ZERO;
        else if (d_den_reg[14:7] != 8'd0)
        begin
            u_m_next  = {1'b1, d_den_reg[6:0]};
            u_next.ed = $signed({4'b0, d_den_reg[14:7]}) - 12'sd127;
        end
        else
        begin
            u_m_next  = {1'b0, d_den_reg[6:0]} << sbta_pkg::lz8({1'b0, d_den_reg[6:0]});
            u_next.ed = -12'sd126 - $signed({9'b0, sbta_pkg::lz8({1'b0, d_den_reg[6:0]})});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg <= 1'b0;
            dv_reg <= 1'b0;
            uv_reg <= 1'b0;
        end
        else
        begin
            ev_reg <= tv_reg[NT];
            dv_reg <= ev_reg;
            uv_reg <= dv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e_sd_reg  <= tay_reg[NT].sd;
        e_val_reg <= sbta_pkg::bf_add(sbta_pkg::BF_ONE, tay_reg[NT].sum);
        d_sd_reg  <= e_sd_reg;
        d_den_reg <= sbta_pkg::bf_add(sbta_pkg::BF_ONE, e_val_reg);
        u_reg     <= u_next;
        u_m_reg   <= u_m_next;
    end

    sbta_recip u_recip
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (uv_reg),
        .m         (u_m_reg),
        .out_valid (rv),
        .q         (rq),
        .rem_nz    (rnz)
    );

    // side data delayed to line up with the reciprocal output
    always_ff @(posedge clk)
    begin
        ln_reg[0] <= u_reg;
        for (int i = 1; i < ND; i++)
            ln_reg[i] <= ln_reg[i-1];
    end

    always_comb
    begin
        case (ln_reg[ND-1].cls)
            sbta_pkg::DEN_NAN:  sig_next = sbta_pkg::BF_QNAN;
            sbta_pkg::DEN_INF:  sig_next = {ln_reg[ND-1].dsign, 15'd0};
            sbta_pkg::DEN_ZERO: sig_next = {ln_reg[ND-1].dsign, 15'h7F80};
            default:
                sig_next = sbta_pkg::round_pack(ln_reg[ND-1].dsign, 12'sd0 - ln_reg[ND-1].ed,
                                                {rq, (32 - ND)'(0)}, rnz);
        endcase
        if (ln_reg[ND-1].sd.gt4)
            sig_next = ln_reg[ND-1].sd.lin;
        if (ln_reg[ND-1].sd.gt7)
            sig_next = sbta_pkg::BF_ONE;
        if (ln_reg[ND-1].sd.ltm7)
            sig_next = 16'h0000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_v_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            r_v_reg  <= rv;
            done_reg <= r_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r_sd_reg  <= ln_reg[ND-1].sd;
        r_sig_reg <= sig_next;
        y_reg     <= sbta_pkg::bf_mul(r_sd_reg.x, r_sig_reg);
    end

    assign done   = done_reg;
    assign y_bits = y_reg;

    // history from before the first clock reads as no beat
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done == ($past(tv_reg[0], sbta_pkg::PIPE_DEPTH) === 1'b1))
        else $error("result strobe out of step with accepted beats");
    a_big_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (r_v_reg && r_sd_reg.gt7) |=> (done && y_bits == $past(r_sd_reg.x)))
        else $error("x above seven must pass through unchanged");
    a_big_neg: assert property (@(posedge clk) disable iff (!rst_n)
        (r_v_reg && r_sd_reg.ltm7 && r_sd_reg.x != 16'hFF80) |=> (y_bits == 16'h8000))
        else $error("finite x below minus seven must give negative zero");

endmodule

`default_nettype wire
